// ===== hdl/two_level_page_table_mapper_unit_assert.svh =====
// Assertion macros for the two-level page table mapper.
// Used by the port checker; needs clk and rst_n in the including scope.
`ifndef TWO_LEVEL_PAGE_TABLE_MAPPER_UNIT_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_MAPPER_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define TLPTM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define TLPTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tlptm_pkg.sv =====
// Shared types and constants of the two-level page table mapper.
// No dependencies.
`default_nettype none

package tlptm_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int SLOTS_MAX       = 1024;
  localparam int IDX_W           = 10;
  localparam int DIR_DEPTH       = 1 << IDX_W;
  localparam int FRAME_W         = 20;
  localparam int WORD_W          = 32;
  localparam int SLOT_FIELD_W    = $clog2(SLOTS_MAX);
  localparam int QUEUE_DEPTH     = 2;

  // Flags kept when an entry is unmapped: everything but present and frame.
  localparam logic [WORD_W-1:0] KEEP_ON_UNMAP = 32'h0000_0FFE;

  typedef enum logic {
    FN_MAP   = 1'b0,
    FN_UNMAP = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_SKIP     = 2'd1,
    ST_NO_TABLE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CK_MAP,
    CK_ALLOC,
    CK_UNMAP,
    CK_SKIP,
    CK_NO_TABLE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                kind;
    logic [SLOT_FIELD_W-1:0]  slot;
    logic [IDX_W-1:0]         tidx;
    logic [WORD_W-1:0]        word;
  } cmd_t;

  typedef struct packed {
    status_t              status;
    logic                 table_allocated;
    logic [FRAME_W-1:0]   table_frame;
    logic [WORD_W-1:0]    entry_word;
  } result_t;

  typedef enum logic [1:0] {
    FS_CLEAR,
    FS_IDLE,
    FS_LOOK
  } front_state_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_SWEEP,
    BS_WRITE,
    BS_READ,
    BS_MODIFY,
    BS_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/tlptm_fifo.sv =====
// Small register queue used between front and back and on the result side.
// No dependencies.
`default_nettype none

module tlptm_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tlptm_front.sv =====
// Front end: takes requests, looks up the page directory, allocates tables.
// Depends on tlptm_pkg.
`default_nettype none

module tlptm_front #(
  parameter int TABLE_SLOTS = tlptm_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_func,
  input  logic [tlptm_pkg::FRAME_W-1:0] in_virt_page,
  input  logic [tlptm_pkg::FRAME_W-1:0] in_phys_frame,
  input  logic                          in_write_allowed,
  input  logic                          in_user_allowed,
  input  logic                          in_write_through,
  input  logic                          in_cache_disable,
  input  logic                          in_accessed_bit,
  input  logic                          in_dirty_bit,
  input  logic                          in_global_bit,
  input  logic [2:0]                    in_avail_bits,
  output logic                          cmd_push,
  input  logic                          cmd_full,
  output tlptm_pkg::cmd_t               cmd
);

  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  tlptm_pkg::front_state_t state_r, state_nxt;

  logic [tlptm_pkg::IDX_W-1:0]  clr_idx_r;
  logic [SW:0]                  dir_mem [tlptm_pkg::DIR_DEPTH];
  logic [SW:0]                  dir_rd_r;
  logic                         dir_we;
  logic [tlptm_pkg::IDX_W-1:0]  dir_waddr;
  logic [SW:0]                  dir_wdata;
  logic [CW-1:0]                next_free_r;
  logic                         alloc;
  logic                         accept;

  tlptm_pkg::func_t             func_r;
  logic [tlptm_pkg::IDX_W-1:0]  didx_r;
  logic [tlptm_pkg::IDX_W-1:0]  tidx_r;
  logic [tlptm_pkg::WORD_W-1:0] word_r;

  assign accept = push && !full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlptm_pkg::FS_CLEAR: begin
        if (clr_idx_r == '1) begin
          state_nxt = tlptm_pkg::FS_IDLE;
        end
      end
      tlptm_pkg::FS_IDLE: begin
        if (accept) begin
          state_nxt = tlptm_pkg::FS_LOOK;
        end
      end
      tlptm_pkg::FS_LOOK: begin
        if (!cmd_full) begin
          state_nxt = tlptm_pkg::FS_IDLE;
        end
      end
      default: state_nxt = tlptm_pkg::FS_CLEAR;
    endcase
  end

  always_comb begin
    full     = (state_r != tlptm_pkg::FS_IDLE);
    cmd_push = (state_r == tlptm_pkg::FS_LOOK) && !cmd_full;
  end

  // Classify the request from the directory entry read at accept.
  always_comb begin
    cmd      = '0;
    alloc    = 1'b0;
    cmd.tidx = tidx_r;
    cmd.word = word_r;
    cmd.slot = tlptm_pkg::SLOT_FIELD_W'(dir_rd_r[SW-1:0]);
    if (func_r == tlptm_pkg::FN_MAP) begin
      if (dir_rd_r[SW]) begin
        cmd.kind = tlptm_pkg::CK_MAP;
      end else if (next_free_r >= CW'(TABLE_SLOTS)) begin
        cmd.kind = tlptm_pkg::CK_NO_TABLE;
      end else begin
        cmd.kind = tlptm_pkg::CK_ALLOC;
        cmd.slot = tlptm_pkg::SLOT_FIELD_W'(next_free_r);
        alloc    = 1'b1;
      end
    end else begin
      cmd.kind = dir_rd_r[SW] ? tlptm_pkg::CK_UNMAP : tlptm_pkg::CK_SKIP;
    end
  end

  always_comb begin
    dir_we    = 1'b0;
    dir_waddr = didx_r;
    dir_wdata = {1'b1, next_free_r[SW-1:0]};
    if (state_r == tlptm_pkg::FS_CLEAR) begin
      dir_we    = 1'b1;
      dir_waddr = clr_idx_r;
      dir_wdata = '0;
    end else if (cmd_push && alloc) begin
      dir_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tlptm_pkg::FS_CLEAR;
      clr_idx_r   <= '0;
      next_free_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == tlptm_pkg::FS_CLEAR) begin
        clr_idx_r <= clr_idx_r + 1'b1;
      end
      if (cmd_push && alloc) begin
        next_free_r <= next_free_r + 1'b1;
      end
    end
  end

  // Directory memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= dir_wdata;
    end
    if (state_r == tlptm_pkg::FS_IDLE) begin
      dir_rd_r <= dir_mem[in_virt_page[2*tlptm_pkg::IDX_W-1:tlptm_pkg::IDX_W]];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= tlptm_pkg::func_t'(in_func);
      didx_r <= in_virt_page[2*tlptm_pkg::IDX_W-1:tlptm_pkg::IDX_W];
      tidx_r <= in_virt_page[tlptm_pkg::IDX_W-1:0];
      word_r <= {in_phys_frame, in_avail_bits, in_global_bit, 1'b0, in_dirty_bit,
                 in_accessed_bit, in_cache_disable, in_write_through,
                 in_user_allowed, in_write_allowed, 1'b1};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tlptm_back.sv =====
// Back end: clears new tables and writes or updates table entries.
// Depends on tlptm_pkg.
`default_nettype none

module tlptm_back #(
  parameter int TABLE_SLOTS = tlptm_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tlptm_pkg::FRAME_W-1:0] pool_base_frame,
  input  logic                          cmd_empty,
  input  tlptm_pkg::cmd_t               cmd,
  output logic                          cmd_pop,
  output logic                          res_push,
  input  logic                          res_full,
  output tlptm_pkg::result_t            res
);

  localparam int SW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int DEPTH = TABLE_SLOTS * tlptm_pkg::DIR_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  tlptm_pkg::back_state_t state_r, state_nxt;

  tlptm_pkg::cmd_t              cur_r;
  logic [tlptm_pkg::IDX_W-1:0]  sweep_r;
  logic [tlptm_pkg::WORD_W-1:0] tbl_mem [DEPTH];
  logic [tlptm_pkg::WORD_W-1:0] rd_word_r;
  logic [SW-1:0]                slot_s;
  logic [tlptm_pkg::IDX_W-1:0]  idx_s;
  logic [AW-1:0]                tbl_addr;
  logic                         tbl_we;
  logic [tlptm_pkg::WORD_W-1:0] tbl_wdata;

  assign slot_s   = cur_r.slot[SW-1:0];
  assign idx_s    = (state_r == tlptm_pkg::BS_SWEEP) ? sweep_r : cur_r.tidx;
  assign tbl_addr = AW'({slot_s, idx_s});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlptm_pkg::BS_IDLE: begin
        if (!cmd_empty) begin
          case (cmd.kind)
            tlptm_pkg::CK_ALLOC: state_nxt = tlptm_pkg::BS_SWEEP;
            tlptm_pkg::CK_MAP:   state_nxt = tlptm_pkg::BS_WRITE;
            tlptm_pkg::CK_UNMAP: state_nxt = tlptm_pkg::BS_READ;
            default:             state_nxt = tlptm_pkg::BS_DONE;
          endcase
        end
      end
      tlptm_pkg::BS_SWEEP: begin
        if (sweep_r == '1) begin
          state_nxt = tlptm_pkg::BS_DONE;
        end
      end
      tlptm_pkg::BS_WRITE:  state_nxt = tlptm_pkg::BS_DONE;
      tlptm_pkg::BS_READ:   state_nxt = tlptm_pkg::BS_MODIFY;
      tlptm_pkg::BS_MODIFY: state_nxt = tlptm_pkg::BS_DONE;
      tlptm_pkg::BS_DONE: begin
        if (!res_full) begin
          state_nxt = tlptm_pkg::BS_IDLE;
        end
      end
      default: state_nxt = tlptm_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = (state_r == tlptm_pkg::BS_IDLE) && !cmd_empty;
    res_push  = (state_r == tlptm_pkg::BS_DONE) && !res_full;
    tbl_we    = 1'b0;
    tbl_wdata = cur_r.word;
    case (state_r)
      tlptm_pkg::BS_SWEEP: begin
        // Zero the fresh table, dropping the new entry in on the way.
        tbl_we    = 1'b1;
        tbl_wdata = (sweep_r == cur_r.tidx) ? cur_r.word : '0;
      end
      tlptm_pkg::BS_WRITE: tbl_we = 1'b1;
      tlptm_pkg::BS_MODIFY: begin
        tbl_we    = 1'b1;
        tbl_wdata = rd_word_r & tlptm_pkg::KEEP_ON_UNMAP;
      end
      default: tbl_we = 1'b0;
    endcase
  end

  always_comb begin
    res = '0;
    case (cur_r.kind)
      tlptm_pkg::CK_SKIP:     res.status = tlptm_pkg::ST_SKIP;
      tlptm_pkg::CK_NO_TABLE: res.status = tlptm_pkg::ST_NO_TABLE;
      default: begin
        res.status          = tlptm_pkg::ST_DONE;
        res.table_allocated = (cur_r.kind == tlptm_pkg::CK_ALLOC);
        res.table_frame     = pool_base_frame + tlptm_pkg::FRAME_W'(slot_s);
        res.entry_word      = cur_r.word;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlptm_pkg::BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_r   <= cmd;
      sweep_r <= '0;
    end else begin
      if (state_r == tlptm_pkg::BS_SWEEP) begin
        sweep_r <= sweep_r + 1'b1;
      end
      if (state_r == tlptm_pkg::BS_MODIFY) begin
        cur_r.word <= tbl_wdata;
      end
    end
  end

  // Table store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end
    if (state_r == tlptm_pkg::BS_READ) begin
      rd_word_r <= tbl_mem[tbl_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/two_level_page_table_mapper_unit.sv =====
// Usage:
// Requests enter through a queue-style port (push/full) and results leave
// through one (empty/pop); every request yields exactly one result, in order.
// cfg_we/cfg_wdata set the frame of pool table 0; write it only while idle.
// After reset the directory is swept clear, one entry a cycle, and full stays
// high until the sweep ends. The front end then takes one request at a time:
// a directory read while idle, then a classify step that holds until the
// command queue has room. The back end, behind a 2-deep command queue, goes
// from idle to done directly for an unmap of an absent table or an exhausted
// pool, through write for a map into an existing table, through read and
// modify for an unmap, and through sweep for a map that takes a new table
// (all 1024 entries written, zero but the new one, through the one write port
// of the table store). Results then pass through a 2-deep result queue.
// When pop stays low the result queue fills, the back end holds, the command
// queue fills and full rises; nothing is dropped.
// Depends on tlptm_pkg, tlptm_fifo, tlptm_front, tlptm_back.
`default_nettype none

module two_level_page_table_mapper_unit #(
  parameter int TABLE_SLOTS = tlptm_pkg::TABLE_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tlptm_pkg::FRAME_W-1:0] cfg_wdata,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_func,
  input  logic [tlptm_pkg::FRAME_W-1:0] in_virt_page,
  input  logic [tlptm_pkg::FRAME_W-1:0] in_phys_frame,
  input  logic                          in_write_allowed,
  input  logic                          in_user_allowed,
  input  logic                          in_write_through,
  input  logic                          in_cache_disable,
  input  logic                          in_accessed_bit,
  input  logic                          in_dirty_bit,
  input  logic                          in_global_bit,
  input  logic [2:0]                    in_avail_bits,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    out_status,
  output logic                          out_table_allocated,
  output logic [tlptm_pkg::FRAME_W-1:0] out_table_frame,
  output logic [tlptm_pkg::WORD_W-1:0]  out_entry_word
);

  localparam int CMD_W = $bits(tlptm_pkg::cmd_t);
  localparam int RES_W = $bits(tlptm_pkg::result_t);

  logic [tlptm_pkg::FRAME_W-1:0] pool_base_frame_r;

  tlptm_pkg::cmd_t    cmd_in, cmd_out;
  tlptm_pkg::result_t res_in, res_out;
  logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic               res_push, res_full;
  logic [CMD_W-1:0]   cmd_rd_data;
  logic [RES_W-1:0]   res_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_frame_r <= '0;
    end else if (cfg_we) begin
      pool_base_frame_r <= cfg_wdata;
    end
  end

  tlptm_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_func          (in_func),
    .in_virt_page     (in_virt_page),
    .in_phys_frame    (in_phys_frame),
    .in_write_allowed (in_write_allowed),
    .in_user_allowed  (in_user_allowed),
    .in_write_through (in_write_through),
    .in_cache_disable (in_cache_disable),
    .in_accessed_bit  (in_accessed_bit),
    .in_dirty_bit     (in_dirty_bit),
    .in_global_bit    (in_global_bit),
    .in_avail_bits    (in_avail_bits),
    .cmd_push         (cmd_push),
    .cmd_full         (cmd_full),
    .cmd              (cmd_in)
  );

  tlptm_fifo #(
    .W     (CMD_W),
    .DEPTH (tlptm_pkg::QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_push),
    .wr_data (cmd_in),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_rd_data),
    .empty   (cmd_empty)
  );

  assign cmd_out = cmd_rd_data;

  tlptm_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pool_base_frame (pool_base_frame_r),
    .cmd_empty       (cmd_empty),
    .cmd             (cmd_out),
    .cmd_pop         (cmd_pop),
    .res_push        (res_push),
    .res_full        (res_full),
    .res             (res_in)
  );

  tlptm_fifo #(
    .W     (RES_W),
    .DEPTH (tlptm_pkg::QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd_data),
    .empty   (empty)
  );

  assign res_out             = res_rd_data;
  assign out_status          = res_out.status;
  assign out_table_allocated = res_out.table_allocated;
  assign out_table_frame     = res_out.table_frame;
  assign out_entry_word      = res_out.entry_word;

endmodule

`default_nettype wire

// ===== hdl/tlptm_checker.sv =====
// Port-level checker for the page table mapper, bound to the top level.
// Depends on tlptm_pkg and two_level_page_table_mapper_unit_assert.svh.
`default_nettype none

module tlptm_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [1:0]                    out_status,
  input wire logic                          out_table_allocated,
  input wire logic [tlptm_pkg::FRAME_W-1:0] out_table_frame,
  input wire logic [tlptm_pkg::WORD_W-1:0]  out_entry_word
);

`include "two_level_page_table_mapper_unit_assert.svh"

  `TLPTM_ASSERT_SAME(a_status_known, !empty, out_status == tlptm_pkg::ST_DONE || out_status == tlptm_pkg::ST_SKIP || out_status == tlptm_pkg::ST_NO_TABLE, "result status code out of range")
  `TLPTM_ASSERT_SAME(a_fail_clean, !empty && out_status != tlptm_pkg::ST_DONE, !out_table_allocated && out_table_frame == '0 && out_entry_word == '0, "failed request carries data")
  `TLPTM_ASSERT_SAME(a_alloc_present, !empty && out_table_allocated, out_status == tlptm_pkg::ST_DONE && out_entry_word[0], "new table without a present entry")
  `TLPTM_ASSERT_NEXT(a_hold_result, !empty && !pop, !empty && $stable(out_entry_word) && $stable(out_table_frame), "stalled result changed")

endmodule

bind two_level_page_table_mapper_unit tlptm_checker u_checker (.*);

`default_nettype wire

// ===== tb/two_level_page_table_mapper_unit_test.sv =====
// Self-checking testbench for the two-level page table mapper: directed rows, then random
// phases with sender gaps, receiver stalls and a long receiver hold-off; a local predictor.
// Depends on tlptm_pkg and two_level_page_table_mapper_unit.
`timescale 1ns / 100ps

module two_level_page_table_mapper_unit_test;
  import tlptm_pkg::*;

  localparam int SLOTS        = TABLE_SLOTS_DEF;
  localparam int CYCLE_LIMIT  = 600_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASE_ITEMS  = 310;
  localparam int PHASE_COUNT  = 5;
  localparam int RECENT_DEPTH = 32;

  typedef struct packed {
    func_t              fn;
    logic [FRAME_W-1:0] vpage;
    logic [FRAME_W-1:0] pframe;
    logic [2:0]         avail;
    logic               glob;
    logic               dirty;
    logic               acc;
    logic               cd;
    logic               wt;
    logic               usr;
    logic               wr;
  } page_req_t;

  typedef struct {
    page_req_t req;
    bit        typed;
    result_t   want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [FRAME_W-1:0] cfg_wdata = '0;
  logic push = 1'b0;
  logic full;
  logic in_func = 1'b0;
  logic [FRAME_W-1:0] in_virt_page = '0;
  logic [FRAME_W-1:0] in_phys_frame = '0;
  logic in_write_allowed = 1'b0;
  logic in_user_allowed = 1'b0;
  logic in_write_through = 1'b0;
  logic in_cache_disable = 1'b0;
  logic in_accessed_bit = 1'b0;
  logic in_dirty_bit = 1'b0;
  logic in_global_bit = 1'b0;
  logic [2:0] in_avail_bits = '0;
  logic empty;
  logic pop = 1'b0;
  logic [1:0] out_status;
  logic out_table_allocated;
  logic [FRAME_W-1:0] out_table_frame;
  logic [WORD_W-1:0] out_entry_word;

  // predictor state
  logic [FRAME_W-1:0] pool_base = '0;
  bit                 dir_present [DIR_DEPTH];
  int                 dir_slot [DIR_DEPTH];
  int                 tables_taken = 0;
  logic [WORD_W-1:0]  table_words [SLOTS*DIR_DEPTH];
  int                 owned_dirs [$];
  logic [FRAME_W-1:0] recent_pages [$];

  result_t   pending_results [$];
  stim_row_t stim_rows [$];
  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  two_level_page_table_mapper_unit #(.TABLE_SLOTS(SLOTS)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .push                (push),
    .full                (full),
    .in_func             (in_func),
    .in_virt_page        (in_virt_page),
    .in_phys_frame       (in_phys_frame),
    .in_write_allowed    (in_write_allowed),
    .in_user_allowed     (in_user_allowed),
    .in_write_through    (in_write_through),
    .in_cache_disable    (in_cache_disable),
    .in_accessed_bit     (in_accessed_bit),
    .in_dirty_bit        (in_dirty_bit),
    .in_global_bit       (in_global_bit),
    .in_avail_bits       (in_avail_bits),
    .empty               (empty),
    .pop                 (pop),
    .out_status          (out_status),
    .out_table_allocated (out_table_allocated),
    .out_table_frame     (out_table_frame),
    .out_entry_word      (out_entry_word)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Walk the directory, take a pool table if needed, and update the entry.
  function automatic result_t apply_page_request(input page_req_t r);
    logic [IDX_W-1:0]  didx;
    logic [IDX_W-1:0]  tidx;
    logic [WORD_W-1:0] word;
    int                at;
    result_t           res;
    didx = r.vpage[FRAME_W-1:IDX_W];
    tidx = r.vpage[IDX_W-1:0];
    res = '0;
    res.status = ST_DONE;
    if (r.fn == FN_MAP) begin
      if (!dir_present[didx]) begin
        if (tables_taken >= SLOTS) begin
          res.status = ST_NO_TABLE;
          return res;
        end
        for (int i = 0; i < DIR_DEPTH; i++) table_words[tables_taken*DIR_DEPTH + i] = '0;
        dir_present[didx] = 1'b1;
        dir_slot[didx] = tables_taken;
        owned_dirs.push_back(int'(didx));
        tables_taken++;
        res.table_allocated = 1'b1;
      end
      word = {r.pframe, r.avail, r.glob, 1'b0, r.dirty, r.acc, r.cd, r.wt, r.usr, r.wr, 1'b1};
    end else begin
      if (!dir_present[didx]) begin
        res.status = ST_SKIP;
        return res;
      end
      word = table_words[dir_slot[didx]*DIR_DEPTH + int'(tidx)] & KEEP_ON_UNMAP;
    end
    at = dir_slot[didx]*DIR_DEPTH + int'(tidx);
    table_words[at] = word;
    res.entry_word = word;
    res.table_frame = pool_base + FRAME_W'(dir_slot[didx]);
    return res;
  endfunction

  function automatic page_req_t make_req(input func_t fn, input logic [FRAME_W-1:0] vpage,
                                         input logic [FRAME_W-1:0] pframe,
                                         input logic [9:0] flags);
    page_req_t r;
    r = {fn, vpage, pframe, flags};
    return r;
  endfunction

  function automatic stim_row_t make_row(input page_req_t req, input bit typed,
                                         input status_t st, input logic alloc,
                                         input logic [FRAME_W-1:0] frame,
                                         input logic [WORD_W-1:0] word);
    stim_row_t row;
    row.req = req;
    row.typed = typed;
    row.want = '0;
    row.want.status = st;
    row.want.table_allocated = alloc;
    row.want.table_frame = frame;
    row.want.entry_word = word;
    return row;
  endfunction

  // Mostly revisit recent pages and owned directories so unmaps hit real entries.
  function automatic page_req_t next_random_request();
    page_req_t r;
    int        pick;
    r = page_req_t'({$urandom, $urandom});
    r.fn = ($urandom_range(0, 99) < 55) ? FN_MAP : FN_UNMAP;
    pick = $urandom_range(0, 99);
    if (pick < 35 && recent_pages.size() > 0)
      r.vpage = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
    else if (pick < 85 && owned_dirs.size() > 0)
      r.vpage = {IDX_W'(owned_dirs[$urandom_range(0, owned_dirs.size() - 1)]),
                 IDX_W'($urandom)};
    else
      r.vpage = FRAME_W'($urandom);
    if (r.fn == FN_MAP) begin
      recent_pages.push_back(r.vpage);
      if (recent_pages.size() > RECENT_DEPTH) void'(recent_pages.pop_front());
    end
    return r;
  endfunction

  task automatic send_request(input page_req_t r, input bit typed, input result_t want);
    result_t got;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_func <= r.fn;
    in_virt_page <= r.vpage;
    in_phys_frame <= r.pframe;
    in_write_allowed <= r.wr;
    in_user_allowed <= r.usr;
    in_write_through <= r.wt;
    in_cache_disable <= r.cd;
    in_accessed_bit <= r.acc;
    in_dirty_bit <= r.dirty;
    in_global_bit <= r.glob;
    in_avail_bits <= r.avail;
    @(posedge clk);
    while (full) @(posedge clk);
    got = apply_page_request(r);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic set_pool_base(input logic [FRAME_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    pool_base = value;
    repeat (2) @(posedge clk);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result transfer with no request waiting");
      error_count++;
    end else begin
      want = pending_results.pop_front();
      if (out_status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, out_status);
        error_count++;
      end
      if (out_table_allocated !== want.table_allocated) begin
        $error("table_allocated: expected %0d, got %0d", want.table_allocated,
               out_table_allocated);
        error_count++;
      end
      if (out_table_frame !== want.table_frame) begin
        $error("table_frame: expected %h, got %h", want.table_frame, out_table_frame);
        error_count++;
      end
      if (out_entry_word !== want.entry_word) begin
        $error("entry_word: expected %h, got %h", want.entry_word, out_entry_word);
        error_count++;
      end
    end
  endtask

  // Result side: check each transfer, then choose the next pop.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && !empty) check_result();
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic load_directed_rows();
    // Pool starts near the top of the frame space so slot frames wrap to zero.
    stim_rows.push_back(make_row(make_req(FN_UNMAP, 20'h00000, 20'h00000, 10'h000), 1'b1,
                                 ST_SKIP, 1'b0, 20'h00000, 32'h0000_0000));
    stim_rows.push_back(make_row(make_req(FN_UNMAP, 20'hFFFFF, 20'hFFFFF, 10'h3FF), 1'b1,
                                 ST_SKIP, 1'b0, 20'h00000, 32'h0000_0000));
    stim_rows.push_back(make_row(make_req(FN_MAP, 20'h00000, 20'hFFFFF, 10'h3FF), 1'b1,
                                 ST_DONE, 1'b1, 20'hFFFFC, 32'hFFFF_FF7F));
    stim_rows.push_back(make_row(make_req(FN_MAP, 20'h003FF, 20'h00000, 10'h000), 1'b1,
                                 ST_DONE, 1'b0, 20'hFFFFC, 32'h0000_0001));
    stim_rows.push_back(make_row(make_req(FN_UNMAP, 20'h003FF, 20'hFFFFF, 10'h3FF), 1'b1,
                                 ST_DONE, 1'b0, 20'hFFFFC, 32'h0000_0000));
    stim_rows.push_back(make_row(make_req(FN_UNMAP, 20'h00000, 20'h00000, 10'h000), 1'b1,
                                 ST_DONE, 1'b0, 20'hFFFFC, 32'h0000_0F7E));
    // entry in a present table that was never mapped
    stim_rows.push_back(make_row(make_req(FN_UNMAP, 20'h00005, 20'h00000, 10'h000), 1'b1,
                                 ST_DONE, 1'b0, 20'hFFFFC, 32'h0000_0000));
    stim_rows.push_back(make_row(make_req(FN_MAP, 20'hFFFFF, 20'h5A5A5, 10'h2AA), 1'b0,
                                 ST_DONE, 1'b0, '0, '0));
    // use up the rest of the pool
    for (int d = 1; d <= SLOTS - 2; d++)
      stim_rows.push_back(make_row(make_req(FN_MAP, {IDX_W'(d), IDX_W'($urandom)},
                                            FRAME_W'($urandom), 10'($urandom)),
                                   1'b0, ST_DONE, 1'b0, '0, '0));
    stim_rows.push_back(make_row(make_req(FN_MAP, 20'h7FC00, 20'h12345, 10'h3FF), 1'b1,
                                 ST_NO_TABLE, 1'b0, 20'h00000, 32'h0000_0000));
    stim_rows.push_back(make_row(make_req(FN_UNMAP, 20'h7FC00, 20'h12345, 10'h3FF), 1'b1,
                                 ST_SKIP, 1'b0, 20'h00000, 32'h0000_0000));
    stim_rows.push_back(make_row(make_req(FN_MAP, 20'hFFC00, 20'hABCDE, 10'h155), 1'b0,
                                 ST_DONE, 1'b0, '0, '0));
  endtask

  initial begin
    logic [FRAME_W-1:0] phase_base [PHASE_COUNT];
    int                 phase_idle [PHASE_COUNT];
    int                 phase_stall [PHASE_COUNT];
    result_t            none;
    phase_base  = '{20'h00000, 20'hFFFFF, 20'h80000, FRAME_W'($urandom), 20'hFFFF8};
    phase_idle  = '{0, 54, 0, 38, 0};
    phase_stall = '{0, 0, 54, 38, 0};
    none = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_pool_base(20'hFFFFC);

    load_directed_rows();
    foreach (stim_rows[i]) send_request(stim_rows[i].req, stim_rows[i].typed, stim_rows[i].want);
    drain_results();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      set_pool_base(phase_base[p]);
      // last phase: hold the result side off while requests keep coming
      if (p == PHASE_COUNT - 1) hold_req++;
      for (int n = 0; n < PHASE_ITEMS; n++) send_request(next_random_request(), 1'b0, none);
      drain_results();
    end

    repeat (16) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tlptm_pkg.sv
hdl/tlptm_fifo.sv
hdl/tlptm_front.sv
hdl/tlptm_back.sv
hdl/two_level_page_table_mapper_unit.sv
hdl/tlptm_checker.sv
tb/two_level_page_table_mapper_unit_test.sv
